[hw/rtl/grf_pkg.sv]
// shared types, constants and glyph font for the 3x5 character renderer
package grf_pkg;

    // default matrix size
    localparam int COLUMNS_DEF = 8;
    localparam int ROWS_DEF    = 8;

    // glyph geometry
    localparam int GLYPH_ROWS = 5;
    localparam int GLYPH_COLS = 3;
    localparam int GLYPH_BITS = GLYPH_ROWS * GLYPH_COLS;

    // request queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // configuration register indexes
    localparam logic CFG_ORIGIN_BOTTOM = 1'b0;
    localparam logic CFG_SNAKE_ROWS    = 1'b1;

    // supported character codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;

    // glyph selects beyond the digits
    localparam logic [3:0] GSEL_BLANK = 4'd10;
    localparam logic [3:0] GSEL_DASH  = 4'd11;
    localparam logic [3:0] GSEL_COLON = 4'd12;
    localparam logic [3:0] GSEL_DOT   = 4'd13;

    // one character request after classification
    typedef struct packed {
        logic [7:0]            pos_x;
        logic [7:0]            pos_y;
        logic [GLYPH_BITS-1:0] mask;
        logic [7:0]            red;
        logic [7:0]            green;
        logic [7:0]            blue;
    } grf_item_t;

    // configuration state
    typedef struct packed {
        logic origin_bottom;
        logic snake_rows;
    } grf_cfg_t;

    // font rows, top row in the high byte, leftmost column in bit 7 of each row
    function automatic logic [39:0] glyph_rom(input logic [3:0] sel);
        logic [39:0] rows;
        begin
            unique case (sel)
                4'd0:       rows = 40'hE0A0A0A0E0;
                4'd1:       rows = 40'h40C04040E0;
                4'd2:       rows = 40'hE020E080E0;
                4'd3:       rows = 40'hE020E020E0;
                4'd4:       rows = 40'hA0A0E02020;
                4'd5:       rows = 40'hE080E020E0;
                4'd6:       rows = 40'hE080E0A0E0;
                4'd7:       rows = 40'hE020404040;
                4'd8:       rows = 40'hE0A0E0A0E0;
                4'd9:       rows = 40'hE0A0E020E0;
                GSEL_DASH:  rows = 40'h0000E00000;
                GSEL_COLON: rows = 40'h0040004000;
                GSEL_DOT:   rows = 40'h0000000040;
                default:    rows = 40'h0000000000;
            endcase
            return rows;
        end
    endfunction

    // character code to glyph select, unknown codes draw blank
    function automatic logic [3:0] glyph_select(input logic [7:0] code);
        logic [7:0] diff;
        logic [3:0] sel;
        begin
            diff = code - CHAR_ZERO;
            priority if (code >= CHAR_ZERO && code <= CHAR_NINE)
                sel = diff[3:0];
            else if (code == CHAR_DASH)
                sel = GSEL_DASH;
            else if (code == CHAR_COLON)
                sel = GSEL_COLON;
            else if (code == CHAR_DOT)
                sel = GSEL_DOT;
            else
                sel = GSEL_BLANK;
            return sel;
        end
    endfunction

    // lit bits in row-major order: bit row*3+col
    function automatic logic [GLYPH_BITS-1:0] glyph_mask(input logic [7:0] code);
        logic [39:0]           rows;
        logic [GLYPH_BITS-1:0] m;
        begin
            rows = glyph_rom(glyph_select(code));
            for (int r = 0; r < GLYPH_ROWS; r++) begin
                for (int c = 0; c < GLYPH_COLS; c++) begin
                    m[r*GLYPH_COLS+c] = rows[39-8*r-c];
                end
            end
            return m;
        end
    endfunction

endpackage

[hw/rtl/grf_front.sv]
// front end: takes character requests, looks up the glyph and clips it to the matrix
module grf_front #(
    parameter int COLUMNS = grf_pkg::COLUMNS_DEF,
    parameter int ROWS    = grf_pkg::ROWS_DEF
) (
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          pos_x,
    input  logic [7:0]          pos_y,
    input  logic [7:0]          char_code,
    input  logic [7:0]          color_red,
    input  logic [7:0]          color_green,
    input  logic [7:0]          color_blue,
    input  logic                q_full,
    output logic                q_push,
    output grf_pkg::grf_item_t  q_item
);

    logic [grf_pkg::GLYPH_BITS-1:0] lit;
    logic [grf_pkg::GLYPH_BITS-1:0] vis;
    logic [grf_pkg::GLYPH_COLS-1:0] in_x;
    logic [grf_pkg::GLYPH_ROWS-1:0] in_y;
    logic [7:0]                     x_pos [grf_pkg::GLYPH_COLS];
    logic [7:0]                     y_pos [grf_pkg::GLYPH_ROWS];

    // per column and per row bounds test after wrap
    always_comb
    begin
        for (int c = 0; c < grf_pkg::GLYPH_COLS; c++) begin
            x_pos[c] = pos_x + 8'(c);
            in_x[c]  = {1'b0, x_pos[c]} < 9'(COLUMNS);
        end
        for (int r = 0; r < grf_pkg::GLYPH_ROWS; r++) begin
            y_pos[r] = pos_y + 8'(r);
            in_y[r]  = {1'b0, y_pos[r]} < 9'(ROWS);
        end
    end

    // lit and visible pixels
    always_comb
    begin
        lit = grf_pkg::glyph_mask(char_code);
        for (int r = 0; r < grf_pkg::GLYPH_ROWS; r++) begin
            for (int c = 0; c < grf_pkg::GLYPH_COLS; c++) begin
                vis[r*grf_pkg::GLYPH_COLS+c] = lit[r*grf_pkg::GLYPH_COLS+c] & in_x[c] & in_y[r];
            end
        end
    end

    // requests with nothing to draw are taken and dropped here
    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready && (vis != '0);

    always_comb
    begin
        q_item.pos_x = pos_x;
        q_item.pos_y = pos_y;
        q_item.mask  = vis;
        q_item.red   = color_red;
        q_item.green = color_green;
        q_item.blue  = color_blue;
    end

endmodule

[hw/rtl/grf_queue.sv]
// two-entry request queue between front and back
module grf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  grf_pkg::grf_item_t  push_item,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output grf_pkg::grf_item_t  head_item
);

    grf_pkg::grf_item_t              mem [grf_pkg::QDEPTH];
    logic [grf_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [grf_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [grf_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [grf_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [grf_pkg::QCNT_W-1:0]      count_reg;
    logic [grf_pkg::QCNT_W-1:0]      count_next;

    assign full       = count_reg == grf_pkg::QCNT_W'(grf_pkg::QDEPTH);
    assign head_valid = count_reg != '0;
    assign head_item  = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == grf_pkg::QPTR_W'(grf_pkg::QDEPTH - 1)) ? '0
                                                                             : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == grf_pkg::QPTR_W'(grf_pkg::QDEPTH - 1)) ? '0
                                                                             : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= grf_pkg::QCNT_W'(grf_pkg::QDEPTH))
        else $error("queue fill count out of range");

endmodule

[hw/rtl/grf_back.sv]
// back end: walks the visible glyph pixels and maps each to its chain index
module grf_back #(
    parameter int COLUMNS = grf_pkg::COLUMNS_DEF,
    parameter int ROWS    = grf_pkg::ROWS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  grf_pkg::grf_cfg_t   cfg,
    input  logic                q_valid,
    input  grf_pkg::grf_item_t  q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [5:0]          led_index,
    output logic [7:0]          out_red,
    output logic [7:0]          out_green,
    output logic [7:0]          out_blue,
    output logic                last_pixel
);

    grf_pkg::grf_item_t             cur_reg;
    grf_pkg::grf_item_t             cur_next;
    logic                           cur_valid_reg;
    logic                           cur_valid_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [5:0]                     led_index_reg;
    logic [5:0]                     led_index_next;
    logic [7:0]                     red_reg;
    logic [7:0]                     green_reg;
    logic [7:0]                     blue_reg;
    logic                           last_reg;
    logic                           last_next;

    logic [grf_pkg::GLYPH_BITS-1:0] pick;
    logic [grf_pkg::GLYPH_BITS-1:0] rest;
    logic [2:0]                     sel_row;
    logic [1:0]                     sel_col;
    logic [7:0]                     x_pos;
    logic [7:0]                     y_pos;
    logic [5:0]                     row_w;
    logic [5:0]                     col_w;
    logic [11:0]                    row_base;
    logic                           slot_free;
    logic                           fire;
    logic                           load;

    // lowest remaining pixel in row-major order
    always_comb
    begin
        pick    = cur_reg.mask & (~cur_reg.mask + 1'b1);
        rest    = cur_reg.mask & ~pick;
        sel_row = '0;
        sel_col = '0;
        for (int r = 0; r < grf_pkg::GLYPH_ROWS; r++) begin
            for (int c = 0; c < grf_pkg::GLYPH_COLS; c++) begin
                if (pick[r*grf_pkg::GLYPH_COLS+c]) begin
                    sel_row = 3'(r);
                    sel_col = 2'(c);
                end
            end
        end
    end

    // matrix position, origin flip, serpentine wiring
    always_comb
    begin
        x_pos    = cur_reg.pos_x + 8'(sel_col);
        y_pos    = cur_reg.pos_y + 8'(sel_row);
        row_w    = cfg.origin_bottom ? 6'(ROWS - 1) - y_pos[5:0] : y_pos[5:0];
        col_w    = (cfg.snake_rows && row_w[0]) ? 6'(COLUMNS - 1) - x_pos[5:0] : x_pos[5:0];
        row_base = 12'(row_w) * 12'(COLUMNS);
        led_index_next = row_base[5:0] + col_w;
        last_next      = rest == '0;
    end

    // handshake between current request, queue and output register
    assign slot_free = !out_valid_reg || out_ready;
    assign fire      = cur_valid_reg && slot_free;
    assign load      = q_valid && (!cur_valid_reg || (fire && last_next));
    assign q_pop     = load;

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        if (load) begin
            cur_next       = q_item;
            cur_valid_next = 1'b1;
        end else if (fire) begin
            cur_next.mask  = rest;
            cur_valid_next = !last_next;
        end
        out_valid_next = slot_free ? fire : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (fire) begin
            led_index_reg <= led_index_next;
            red_reg       <= cur_reg.red;
            green_reg     <= cur_reg.green;
            blue_reg      <= cur_reg.blue;
            last_reg      <= last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign led_index  = led_index_reg;
    assign out_red    = red_reg;
    assign out_green  = green_reg;
    assign out_blue   = blue_reg;
    assign last_pixel = last_reg;

    a_cur_has_pixels: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (cur_reg.mask != '0))
        else $error("active request has no pixels left");

    a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> cur_valid_reg)
        else $error("non-final pixel shown with no request in progress");

    a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (!cur_valid_reg || (fire && last_next)))
        else $error("request loaded over one still in progress");

endmodule

[hw/rtl/glyph_to_led_pixel_renderer.sv]
// top level of the 3x5 character renderer for a serially wired led matrix
//
//  channel   direction  handshake             payload
//  in        request    in_valid / in_ready   pos_x pos_y char_code color_red/green/blue
//  out       result     out_valid / out_ready led_index out_red/green/blue last_pixel
//  cfg       write      cfg_we                cfg_index cfg_data
//
// one pixel leaves per cycle while out_ready is high; a character gives one per visible
// lit pixel, 1 to 13, from the pixel walker in the back end. characters with nothing to
// draw are accepted and give no result. pixels pass the queue, current request and output
// registers. a two-request queue lets the front keep accepting while the back is stalled.
// reset clears control state only; configuration resets to origin top and serpentine rows.
module glyph_to_led_pixel_renderer #(
    parameter int COLUMNS = grf_pkg::COLUMNS_DEF,
    parameter int ROWS    = grf_pkg::ROWS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  pos_x,
    input  logic [7:0]  pos_y,
    input  logic [7:0]  char_code,
    input  logic [7:0]  color_red,
    input  logic [7:0]  color_green,
    input  logic [7:0]  color_blue,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  led_index,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic        last_pixel
);

    grf_pkg::grf_cfg_t  cfg_reg;
    grf_pkg::grf_cfg_t  cfg_next;
    grf_pkg::grf_item_t push_item;
    grf_pkg::grf_item_t head_item;
    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_valid;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                grf_pkg::CFG_ORIGIN_BOTTOM: cfg_next.origin_bottom = cfg_data;
                grf_pkg::CFG_SNAKE_ROWS:    cfg_next.snake_rows    = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.origin_bottom <= 1'b0;
            cfg_reg.snake_rows    <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // request classification
    grf_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .char_code   (char_code),
        .color_red   (color_red),
        .color_green (color_green),
        .color_blue  (color_blue),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (push_item)
    );

    // decoupling queue
    grf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (head_item)
    );

    // pixel walker and output register
    grf_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_item     (head_item),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .led_index  (led_index),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .last_pixel (last_pixel)
    );

endmodule

[bench/glyph_to_led_pixel_renderer_test.sv]
// testbench for the 3x5 glyph renderer: queued request driver, pixel monitor and own predictor
module glyph_to_led_pixel_renderer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS        = grf_pkg::COLUMNS_DEF;
    localparam int ROWS_N      = grf_pkg::ROWS_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE      = 8;

    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // one character request as driven on the input channel
    typedef struct packed {
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] code;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } glyph_req_t;

    // one pixel write as expected on the output channel
    typedef struct packed {
        logic [5:0] led;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } pixel_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_we      = 1'b0;
    logic       cfg_index   = 1'b0;
    logic       cfg_data    = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [7:0] pos_x       = '0;
    logic [7:0] pos_y       = '0;
    logic [7:0] char_code   = '0;
    logic [7:0] color_red   = '0;
    logic [7:0] color_green = '0;
    logic [7:0] color_blue  = '0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic [5:0] led_index;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last_pixel;

    // requests still to send, and pixel writes still owed by the block
    glyph_req_t glyphs_waiting[$];
    pixel_t     pixels_due[$];
    glyph_req_t on_wire;
    pixel_t     pixel_want;
    bit         slot_free;

    // predictor copy of the configuration, reset values
    logic flip_rows    = 1'b0;
    logic snake_wiring = 1'b1;

    int send_idle = 0;
    int recv_idle = 0;
    int mismatches = 0;
    int glyphs_sent = 0;
    int blank_glyphs = 0;
    int pixels_checked = 0;
    int stall_cycles = 0;

    glyph_to_led_pixel_renderer #(
        .COLUMNS(COLS),
        .ROWS(ROWS_N)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .char_code(char_code),
        .color_red(color_red),
        .color_green(color_green),
        .color_blue(color_blue),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .led_index(led_index),
        .out_red(out_red),
        .out_green(out_green),
        .out_blue(out_blue),
        .last_pixel(last_pixel)
    );

    // clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // font: bit 14 is top row, left column; three bits per row
    function automatic logic [14:0] font_bits(input logic [7:0] code);
        logic [14:0] bits;
        logic [7:0]  digit;
        begin
            bits  = '0;
            digit = code - grf_pkg::CHAR_ZERO;
            if (code >= grf_pkg::CHAR_ZERO && code <= grf_pkg::CHAR_NINE)
            begin
                case (digit)
                    8'd0: bits = 15'b111_101_101_101_111;
                    8'd1: bits = 15'b010_110_010_010_111;
                    8'd2: bits = 15'b111_001_111_100_111;
                    8'd3: bits = 15'b111_001_111_001_111;
                    8'd4: bits = 15'b101_101_111_001_001;
                    8'd5: bits = 15'b111_100_111_001_111;
                    8'd6: bits = 15'b111_100_111_101_111;
                    8'd7: bits = 15'b111_001_010_010_010;
                    8'd8: bits = 15'b111_101_111_101_111;
                    default: bits = 15'b111_101_111_001_111;
                endcase
            end
            else if (code == grf_pkg::CHAR_DASH)
                bits = 15'b000_000_111_000_000;
            else if (code == grf_pkg::CHAR_COLON)
                bits = 15'b000_010_000_010_000;
            else if (code == grf_pkg::CHAR_DOT)
                bits = 15'b000_000_000_000_010;
            return bits;
        end
    endfunction

    // walk the lit glyph bits and queue the pixel writes they should produce
    task automatic draw_glyph(input glyph_req_t g);
        logic [14:0] bits;
        logic [7:0]  x;
        logic [7:0]  y;
        int          row;
        int          col;
        pixel_t      held;
        bit          have_held;
        begin
            bits      = font_bits(g.code);
            have_held = 1'b0;
            held      = '0;
            for (int r = 0; r < grf_pkg::GLYPH_ROWS; r++)
            begin
                for (int c = 0; c < grf_pkg::GLYPH_COLS; c++)
                begin
                    if (bits[14 - grf_pkg::GLYPH_COLS*r - c])
                    begin
                        x = g.pos_x + 8'(c);
                        y = g.pos_y + 8'(r);
                        if (x < COLS && y < ROWS_N)
                        begin
                            row = y;
                            col = x;
                            if (flip_rows)
                                row = ROWS_N - 1 - row;
                            if (snake_wiring && (row % 2) == 1)
                                col = COLS - 1 - col;
                            // hold one back so the final pixel can be marked
                            if (have_held)
                                pixels_due.push_back(held);
                            held.led   = 6'(row * COLS + col);
                            held.red   = g.red;
                            held.green = g.green;
                            held.blue  = g.blue;
                            held.last  = 1'b0;
                            have_held  = 1'b1;
                        end
                    end
                end
            end
            if (have_held)
            begin
                held.last = 1'b1;
                pixels_due.push_back(held);
            end
            else
                blank_glyphs++;
        end
    endtask

    task automatic note_mismatch(input string what);
        begin
            mismatches++;
            $display("mismatch at %0t ns: %s", $time, what);
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            slot_free = !in_valid || in_ready;
            if (in_valid && in_ready)
            begin
                draw_glyph(on_wire);
                glyphs_sent++;
            end
            if (slot_free)
            begin
                if (glyphs_waiting.size() > 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    on_wire = glyphs_waiting.pop_front();
                    in_valid    <= 1'b1;
                    pos_x       <= on_wire.pos_x;
                    pos_y       <= on_wire.pos_y;
                    char_code   <= on_wire.code;
                    color_red   <= on_wire.red;
                    color_green <= on_wire.green;
                    color_blue  <= on_wire.blue;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // pixel monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pixels_due.size() == 0)
                note_mismatch($sformatf("pixel for led %0d with nothing expected", led_index));
            else
            begin
                pixel_want = pixels_due.pop_front();
                pixels_checked++;
                if (led_index !== pixel_want.led)
                    note_mismatch($sformatf("led_index %0d, want %0d",
                                            led_index, pixel_want.led));
                if (out_red !== pixel_want.red)
                    note_mismatch($sformatf("out_red %0h, want %0h", out_red, pixel_want.red));
                if (out_green !== pixel_want.green)
                    note_mismatch($sformatf("out_green %0h, want %0h",
                                            out_green, pixel_want.green));
                if (out_blue !== pixel_want.blue)
                    note_mismatch($sformatf("out_blue %0h, want %0h", out_blue, pixel_want.blue));
                if (last_pixel !== pixel_want.last)
                    note_mismatch($sformatf("last_pixel %0b, want %0b",
                                            last_pixel, pixel_want.last));
            end
        end
    end

    // count cycles with no traffic at all
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // watchdog
    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("watchdog: no traffic for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic push_glyph(input logic [7:0] x, input logic [7:0] y, input logic [7:0] code,
                              input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        glyph_req_t req;
        begin
            req.pos_x = x;
            req.pos_y = y;
            req.code  = code;
            req.red   = r;
            req.green = g;
            req.blue  = b;
            glyphs_waiting.push_back(req);
        end
    endtask

    // mostly drawable characters near the matrix, some random noise
    function automatic glyph_req_t random_glyph();
        glyph_req_t req;
        int         pick;
        begin
            req.red   = 8'($urandom);
            req.green = 8'($urandom);
            req.blue  = 8'($urandom);
            if ($urandom_range(0, 99) < 80)
            begin
                pick = $urandom_range(0, 13);
                if (pick < 10)
                    req.code = grf_pkg::CHAR_ZERO + 8'(pick);
                else if (pick == 10)
                    req.code = grf_pkg::CHAR_DASH;
                else if (pick == 11)
                    req.code = grf_pkg::CHAR_COLON;
                else if (pick == 12)
                    req.code = grf_pkg::CHAR_DOT;
                else
                    req.code = CHAR_SPACE;
                if ($urandom_range(0, 99) < 85)
                begin
                    // from two left of or above the matrix to its far edge
                    req.pos_x = 8'($urandom_range(0, COLS + 1)) - 8'd2;
                    req.pos_y = 8'($urandom_range(0, ROWS_N + 1)) - 8'd2;
                end
                else
                begin
                    req.pos_x = 8'($urandom);
                    req.pos_y = 8'($urandom);
                end
            end
            else
            begin
                req.code  = 8'($urandom);
                req.pos_x = 8'($urandom);
                req.pos_y = 8'($urandom);
            end
            return req;
        end
    endfunction

    // wait until every request has gone in and every pixel has come out
    task automatic drain();
        begin
            @(negedge clk);
            while (glyphs_waiting.size() != 0 || in_valid || pixels_due.size() != 0)
                @(negedge clk);
        end
    endtask

    // drained, then an idle wait before the next phase or the end of the run
    task automatic settle();
        begin
            drain();
            repeat (SETTLE) @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic idx, input logic val);
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(posedge clk);
            cfg_we <= 1'b0;
            if (idx == grf_pkg::CFG_ORIGIN_BOTTOM)
                flip_rows = val;
            else
                snake_wiring = val;
        end
    endtask

    // one configuration setting, with a full stop by the sender halfway through
    task automatic run_phase(input logic ob, input logic sr, input int s_idle,
                             input int r_idle, input int count);
        begin
            settle();
            write_reg(grf_pkg::CFG_ORIGIN_BOTTOM, ob);
            write_reg(grf_pkg::CFG_SNAKE_ROWS, sr);
            @(negedge clk);
            send_idle = s_idle;
            recv_idle = r_idle;
            for (int i = 0; i < count / 2; i++)
                glyphs_waiting.push_back(random_glyph());
            drain();
            for (int i = count / 2; i < count; i++)
                glyphs_waiting.push_back(random_glyph());
        end
    endtask

    // stimulus and end of run
    initial
    begin
        send_idle = 34;
        recv_idle = 77;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: every glyph, blanks, wrap-around and clipping at reset settings
        push_glyph(8'd0, 8'd0, grf_pkg::CHAR_ZERO, 8'hFF, 8'hFF, 8'hFF);
        push_glyph(8'd4, 8'd0, grf_pkg::CHAR_ZERO + 8'd1, 8'h00, 8'h00, 8'h00);
        push_glyph(8'd0, 8'd3, grf_pkg::CHAR_ZERO + 8'd2, 8'h12, 8'h34, 8'h56);
        push_glyph(8'd5, 8'd3, grf_pkg::CHAR_ZERO + 8'd3, 8'hAA, 8'h55, 8'h0F);
        push_glyph(8'd0, 8'd1, grf_pkg::CHAR_ZERO + 8'd4,
                   8'($urandom), 8'($urandom), 8'($urandom));
        push_glyph(8'd2, 8'd2, grf_pkg::CHAR_ZERO + 8'd5,
                   8'($urandom), 8'($urandom), 8'($urandom));
        push_glyph(8'd5, 8'd2, grf_pkg::CHAR_ZERO + 8'd6,
                   8'($urandom), 8'($urandom), 8'($urandom));
        push_glyph(8'd1, 8'd3, grf_pkg::CHAR_ZERO + 8'd7,
                   8'($urandom), 8'($urandom), 8'($urandom));
        push_glyph(8'd3, 8'd1, grf_pkg::CHAR_ZERO + 8'd8,
                   8'($urandom), 8'($urandom), 8'($urandom));
        push_glyph(8'd5, 8'd0, grf_pkg::CHAR_NINE,
                   8'($urandom), 8'($urandom), 8'($urandom));
        push_glyph(8'd2, 8'd4, grf_pkg::CHAR_DASH,
                   8'($urandom), 8'($urandom), 8'($urandom));
        push_glyph(8'd6, 8'd3, grf_pkg::CHAR_COLON,
                   8'($urandom), 8'($urandom), 8'($urandom));
        push_glyph(8'd6, 8'd3, grf_pkg::CHAR_DOT,
                   8'($urandom), 8'($urandom), 8'($urandom));
        // codes with no glyph
        push_glyph(8'd0, 8'd0, CHAR_SPACE, 8'hFF, 8'hFF, 8'hFF);
        push_glyph(8'd0, 8'd0, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        push_glyph(8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        push_glyph(8'd3, 8'd3, grf_pkg::CHAR_ZERO - 8'd1, 8'hFF, 8'h00, 8'hFF);
        push_glyph(8'd3, 8'd3, grf_pkg::CHAR_COLON + 8'd1, 8'h00, 8'hFF, 8'h00);
        // positions that wrap past 255 back onto the matrix
        push_glyph(8'hFF, 8'hFF, grf_pkg::CHAR_ZERO + 8'd8,
                   8'($urandom), 8'($urandom), 8'($urandom));
        push_glyph(8'hFE, 8'hFE, grf_pkg::CHAR_ZERO,
                   8'($urandom), 8'($urandom), 8'($urandom));
        push_glyph(8'hFF, 8'd0, grf_pkg::CHAR_DASH,
                   8'($urandom), 8'($urandom), 8'($urandom));
        // partly and wholly off the matrix
        push_glyph(8'd6, 8'd5, grf_pkg::CHAR_ZERO + 8'd8,
                   8'($urandom), 8'($urandom), 8'($urandom));
        push_glyph(8'd8, 8'd0, grf_pkg::CHAR_ZERO + 8'd1,
                   8'($urandom), 8'($urandom), 8'($urandom));
        push_glyph(8'd0, 8'd8, grf_pkg::CHAR_ZERO + 8'd1,
                   8'($urandom), 8'($urandom), 8'($urandom));
        push_glyph(8'd200, 8'd100, grf_pkg::CHAR_ZERO,
                   8'($urandom), 8'($urandom), 8'($urandom));

        // random phases over all four settings, then the stall pattern swapped and removed
        run_phase(1'b0, 1'b0, 34, 77, 24);
        run_phase(1'b1, 1'b1, 77, 34, 24);
        run_phase(1'b1, 1'b0, 77, 34, 24);
        run_phase(1'b0, 1'b1, 0, 0, 24);

        settle();
        $display("ran %0d characters (%0d drawing nothing) and checked %0d pixel writes",
                 glyphs_sent, blank_glyphs, pixels_checked);
        $display("covered both row origins and both wirings under sender and receiver stalls");
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
